/* design/mbrtu_pkg.sv */
// ----------------------------------------------------------------------------
// mbrtu_pkg: shared constants, types and crc helper for the modbus rtu slave
// sizes of the stores, function codes and the byte-wise crc-16 update
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int REG_COUNT = 64;
  localparam int RX_DEPTH  = 64;
  localparam int MAX_READ  = 29;

  localparam int REG_AW = $clog2(REG_COUNT);
  localparam int RX_AW  = $clog2(RX_DEPTH);
  localparam int CNT_W  = $clog2(RX_DEPTH + 1);

  localparam logic [7:0]  FC_READ   = 8'h03;
  localparam logic [7:0]  FC_COIL   = 8'h05;
  localparam logic [7:0]  FC_WRITE  = 8'h06;
  localparam logic [7:0]  FC_WRMULT = 8'h10;
  localparam logic [7:0]  FC_EXC    = 8'h80;
  localparam logic [7:0]  EXC_ADDR  = 8'h02;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] COIL_ON   = 16'hFF00;
  localparam logic [15:0] COIL_OFF  = 16'h0000;
  localparam logic [15:0] LED_REG   = 16'h0001;

  // holding register file request
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [REG_AW-1:0] raddr;
  } rf_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* design/mbrtu_regfile.sv */
// ----------------------------------------------------------------------------
// mbrtu_regfile: holding register file
// one write and one registered read port, per-entry valid bits give zero reset
// ----------------------------------------------------------------------------
module mbrtu_regfile
  import mbrtu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rf_req_t     req_i,
  output logic [15:0] rdata_o
);

  logic [15:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [15:0]          rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  // never written entries read as zero
  assign rdata_o = rvld_q ? rdata_q : 16'h0000;

endmodule

/* design/modbus_rtu_slave_frame_engine.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine: modbus rtu slave with crc-16 check
// buffers a request frame, serves functions 03/05/06/10 and streams the reply
// ----------------------------------------------------------------------------
// Request bytes are taken one per cycle while the engine is receiving; the byte
// with tlast closes the frame. In the next cycle the frame is judged (address,
// crc, function, length, range) and the reply is streamed out byte by byte
// while the output side is ready, pausing for each register read (function
// 03). Input is not taken from frame end until the last reply byte has been
// loaded into the output register. Each register written (function 10) passes
// through the states ST_WMA, ST_WMB and ST_WMC; the buffer and register
// memories are read through registered ports.
// Frames with overflow, fewer than 8 bytes, wrong address, bad crc, function
// 01 or unknown codes produce no reply. Holding registers read as zero until
// written, through valid bits cleared at reset; no clearing pass is needed.
module modbus_rtu_slave_frame_engine
  import mbrtu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: slave_address
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tlast_i,   // frame_end
  // reply stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] tx_byte, [8] led_on, [15:9] zero
  output logic        m_axis_tlast_o    // tx_last
);

  // sequencer states
  localparam logic [3:0] ST_RX   = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;
  localparam logic [3:0] ST_WMA  = 4'd2;
  localparam logic [3:0] ST_WMB  = 4'd3;
  localparam logic [3:0] ST_WMC  = 4'd4;
  localparam logic [3:0] ST_HDR  = 4'd5;
  localparam logic [3:0] ST_RDA  = 4'd6;
  localparam logic [3:0] ST_RDH  = 4'd7;
  localparam logic [3:0] ST_RDL  = 4'd8;
  localparam logic [3:0] ST_CRCL = 4'd9;
  localparam logic [3:0] ST_CRCH = 4'd10;

  // reply kinds
  localparam logic [1:0] KIND_EXC  = 2'd0;
  localparam logic [1:0] KIND_RD   = 2'd1;
  localparam logic [1:0] KIND_ECHO = 2'd2;

  logic [3:0]       state_q, state_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       addr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [15:0]      rx_crc_q, rx_crc_d;
  logic [15:0]      tx_crc_q, tx_crc_d;
  logic [7:0]       hdr_q [6];
  logic [2:0]       hidx_q, hidx_d;
  logic [6:0]       k_q, k_d;
  logic [7:0]       hi_q, hi_d;
  logic             led_q, led_d;

  // output register
  logic             out_v_q;
  logic [7:0]       out_b_q;
  logic             out_l_q;
  logic             out_led_q;

  // receive buffer memory
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [7:0]       rx_rdata_q;
  logic             rx_re;
  logic [RX_AW-1:0] rx_raddr;

  rf_req_t          rf_req;
  logic [15:0]      rf_rdata;

  logic             in_xfer;
  logic             out_free;
  logic             emit_v;
  logic [7:0]       emit_b;
  logic             emit_l;

  // decoded request fields
  logic [7:0]       fc;
  logic [15:0]      start;
  logic [15:0]      qty;
  logic [16:0]      span;
  logic [17:0]      need_len;
  logic             frame_ok;
  logic [6:0]       rd_off;

  assign fc       = hdr_q[1];
  assign start    = {hdr_q[2], hdr_q[3]};
  assign qty      = {hdr_q[4], hdr_q[5]};
  assign span     = {1'b0, start} + {1'b0, qty};
  assign need_len = 18'd9 + {1'b0, qty, 1'b0};
  assign frame_ok = !ovf_q && (cnt_q >= CNT_W'(8)) && (hdr_q[0] == addr_q)
                    && (rx_crc_q == 16'h0000)
                    && (fc == FC_READ || fc == FC_COIL || fc == FC_WRITE || fc == FC_WRMULT);
  // data byte offset of register k in a write-multiple frame
  assign rd_off   = {k_q[5:0], 1'b0} + 7'd7;

  assign s_axis_tready_o = (state_q == ST_RX);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_v_q || m_axis_tready_i;

  mbrtu_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rf_req),
    .rdata_o (rf_rdata)
  );

  // receive buffer, written while receiving, read during write-multiple
  always_ff @(posedge clk_i) begin
    if (in_xfer && (cnt_q < CNT_W'(RX_DEPTH))) begin
      rx_mem[cnt_q[RX_AW-1:0]] <= s_axis_tdata_i;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[rx_raddr];
    end
  end

  // first six bytes kept in flops for decoding and the echo reply
  always_ff @(posedge clk_i) begin
    if (in_xfer && (cnt_q < CNT_W'(6))) begin
      hdr_q[cnt_q[2:0]] <= s_axis_tdata_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    rx_crc_d = rx_crc_q;
    tx_crc_d = tx_crc_q;
    hidx_d   = hidx_q;
    k_d      = k_q;
    hi_d     = hi_q;
    led_d    = led_q;
    rx_re    = 1'b0;
    rx_raddr = rd_off[RX_AW-1:0];
    rf_req   = '0;
    emit_v   = 1'b0;
    emit_b   = 8'h00;
    emit_l   = 1'b0;

    case (state_q)
      ST_RX: begin
        if (in_xfer) begin
          if (cnt_q < CNT_W'(RX_DEPTH)) begin
            cnt_d    = cnt_q + CNT_W'(1);
            rx_crc_d = crc_byte(rx_crc_q, s_axis_tdata_i);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        // judge the frame, then clear receive state for the next one
        cnt_d    = '0;
        ovf_d    = 1'b0;
        rx_crc_d = CRC_INIT;
        tx_crc_d = CRC_INIT;
        hidx_d   = '0;
        k_d      = '0;
        state_d  = ST_RX;
        if (frame_ok) begin
          if (fc == FC_READ) begin
            state_d = ST_HDR;
            if (qty > 16'(MAX_READ) || span > 17'(REG_COUNT)) begin
              kind_d = KIND_EXC;
            end else begin
              kind_d = KIND_RD;
            end
          end else if (fc == FC_COIL || fc == FC_WRITE) begin
            state_d = ST_HDR;
            if (start >= 16'(REG_COUNT)) begin
              kind_d = KIND_EXC;
            end else begin
              kind_d       = KIND_ECHO;
              rf_req.we    = 1'b1;
              rf_req.waddr = start[REG_AW-1:0];
              rf_req.wdata = qty;
              if (fc == FC_COIL && start == LED_REG) begin
                if (qty == COIL_ON) begin
                  led_d = 1'b1;
                end else if (qty == COIL_OFF) begin
                  led_d = 1'b0;
                end
              end
            end
          end else begin
            // write multiple; too short a frame is silently dropped
            if (need_len <= {{(18-CNT_W){1'b0}}, cnt_q}) begin
              if (span > 17'(REG_COUNT)) begin
                kind_d  = KIND_EXC;
                state_d = ST_HDR;
              end else begin
                kind_d  = KIND_ECHO;
                state_d = (qty == 16'h0000) ? ST_HDR : ST_WMA;
              end
            end
          end
        end
      end
      ST_WMA: begin
        rx_re   = 1'b1;
        state_d = ST_WMB;
      end
      ST_WMB: begin
        hi_d     = rx_rdata_q;
        rx_re    = 1'b1;
        rx_raddr = rd_off[RX_AW-1:0] + RX_AW'(1);
        state_d  = ST_WMC;
      end
      ST_WMC: begin
        rf_req.we    = 1'b1;
        rf_req.waddr = start[REG_AW-1:0] + k_q[REG_AW-1:0];
        rf_req.wdata = {hi_q, rx_rdata_q};
        k_d          = k_q + 7'd1;
        state_d      = ((k_q + 7'd1) == qty[6:0]) ? ST_HDR : ST_WMA;
      end
      ST_HDR: begin
        emit_v = 1'b1;
        case (kind_q)
          KIND_EXC: begin
            case (hidx_q)
              3'd0:    emit_b = hdr_q[0];
              3'd1:    emit_b = fc | FC_EXC;
              default: emit_b = EXC_ADDR;
            endcase
          end
          KIND_RD: begin
            case (hidx_q)
              3'd0:    emit_b = hdr_q[0];
              3'd1:    emit_b = fc;
              default: emit_b = {hdr_q[5][6:0], 1'b0};
            endcase
          end
          default: begin
            emit_b = (hidx_q < 3'd6) ? hdr_q[hidx_q] : 8'h00;
          end
        endcase
        if (out_free) begin
          hidx_d = hidx_q + 3'd1;
          if (hidx_q == ((kind_q == KIND_ECHO) ? 3'd5 : 3'd2)) begin
            if (kind_q == KIND_RD && qty != 16'h0000) begin
              state_d = ST_RDA;
            end else begin
              state_d = ST_CRCL;
            end
          end
        end
      end
      ST_RDA: begin
        rf_req.re    = 1'b1;
        rf_req.raddr = start[REG_AW-1:0] + k_q[REG_AW-1:0];
        state_d      = ST_RDH;
      end
      ST_RDH: begin
        emit_v = 1'b1;
        emit_b = rf_rdata[15:8];
        if (out_free) begin
          state_d = ST_RDL;
        end
      end
      ST_RDL: begin
        emit_v = 1'b1;
        emit_b = rf_rdata[7:0];
        if (out_free) begin
          k_d     = k_q + 7'd1;
          state_d = ((k_q + 7'd1) == qty[6:0]) ? ST_CRCL : ST_RDA;
        end
      end
      ST_CRCL: begin
        emit_v = 1'b1;
        emit_b = tx_crc_q[7:0];
        if (out_free) begin
          state_d = ST_CRCH;
        end
      end
      ST_CRCH: begin
        emit_v = 1'b1;
        emit_b = tx_crc_q[15:8];
        emit_l = 1'b1;
        if (out_free) begin
          state_d = ST_RX;
        end
      end
      default: begin
        state_d = ST_RX;
      end
    endcase

    // running reply crc over the bytes before the crc itself
    if (emit_v && out_free && state_q != ST_CRCL && state_q != ST_CRCH) begin
      tx_crc_d = crc_byte(tx_crc_q, emit_b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RX;
      kind_q   <= KIND_EXC;
      addr_q   <= 8'd1;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      rx_crc_q <= CRC_INIT;
      tx_crc_q <= CRC_INIT;
      hidx_q   <= '0;
      k_q      <= '0;
      hi_q     <= '0;
      led_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      rx_crc_q <= rx_crc_d;
      tx_crc_q <= tx_crc_d;
      hidx_q   <= hidx_d;
      k_q      <= k_d;
      hi_q     <= hi_d;
      led_q    <= led_d;
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
      if (emit_v && out_free) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // output payload, loaded on each emitted byte
  always_ff @(posedge clk_i) begin
    if (emit_v && out_free) begin
      out_b_q   <= emit_b;
      out_l_q   <= emit_l;
      out_led_q <= led_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {7'h00, out_led_q, out_b_q};
  assign m_axis_tlast_o  = out_l_q;

  // receive count never passes the buffer depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RX_DEPTH))
    else $error("receive count beyond buffer depth");

  // register file writes only come from the judge or write-multiple steps
  a_rf_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_req.we |-> (state_q == ST_CHK || state_q == ST_WMC))
    else $error("unexpected register file write");

  // frame end always leads to the judge state
  a_end_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast_i) |=> (state_q == ST_CHK))
    else $error("frame end not judged");

  // a loaded reply byte is never overwritten before transfer
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready_i) |=> (out_v_q && $stable(out_b_q)))
    else $error("reply byte lost");

endmodule
